[sv/pczb_pkg.sv]
// shared types and constants of the point cloud z-buffer
package pczb_pkg;

	localparam int ACC_W   = 50;          // camera accumulator, 30 fraction bits
	localparam int C_W     = 36;          // camera coordinate, Q20.16
	localparam int DVD_W   = C_W + 16;    // dividend of the ratio divider
	localparam int U_W     = 50;          // projected coordinate before rounding
	localparam int ADDR_W  = 16;          // depth store address
	localparam int DEPTH_W = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam logic [DEPTH_W-1:0] DEPTH_EMPTY    = 32'hFFFF_FFFF;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX_KEPT = 32'hFFFF_FFFE;

	typedef enum logic [2:0] {
		REG_ROT0, REG_ROT1, REG_ROT2, REG_TRANS_XY,
		REG_TRANS_Z, REG_FOCAL, REG_CENTER, REG_SIZE
	} pczb_reg_t;

	typedef struct packed {
		logic [63:0] rot0;
		logic [63:0] rot1;
		logic [63:0] rot2;
		logic [63:0] trans_xy;
		logic [31:0] trans_z;
		logic [63:0] focal;
		logic [63:0] center;
		logic [31:0] size;
	} pczb_cfg_t;

	// one store operation handed from the front to the back
	typedef struct packed {
		logic               is_read;
		logic [ADDR_W-1:0]  addr;
		logic [DEPTH_W-1:0] depth;
	} pczb_op_t;

endpackage

[sv/point_cloud_zbuffer_projection.sv]
// top level of the pinhole point cloud z-buffer
//
// input channel (in_valid / in_stall): kind 0 carries a world point in
//   x_coord, y_coord, z_coord (signed Q16.16); kind 1 reads one pixel of the
//   depth store at pixel_address and clears it back to empty
// output channel (out_valid / out_stall): one transfer per read item with the
//   stored depth and pixel_empty; point items give no transfer
// configuration: cfg_write, cfg_index, cfg_data write one register per cycle;
//   the user must write only while the block is idle; the block does not enforce it
// sequence: a point keeps in_stall high through 10 transform steps, rounding,
//   52 divider steps, two multiplies, projection, address and push, so a new
//   point waits until the last one is through; a point is dropped after rounding
//   when its depth is not positive, or after the address step when outside the
//   image; a read goes through the front's push state, then the back's idle and
//   read-modify-write states into the result register, which must empty first
// reset: registers return to identity pose, fx = fy = 256, cx = cy = 128 and
//   a 256 by 256 image; then a clearing pass writes empty to all 65536 store
//   entries, one per cycle, while in_stall stays high
// stall: a stalled result waits in the output register; the back stops
//   taking reads, the queue fills, and the front then holds its last item
module point_cloud_zbuffer_projection #(
	parameter int MAX_WIDTH  = pczb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pczb_pkg::DEF_MAX_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic signed [31:0] z_coord,
	input  logic [15:0]        pixel_address,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        depth_value,
	output logic               pixel_empty
);
	pczb_pkg::pczb_cfg_t cfg_q;
	pczb_pkg::pczb_op_t  push_op, head;
	logic                push, full, pop, empty, clearing;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot0     <= 64'h0000_0000_0000_4000;
			cfg_q.rot1     <= 64'h0000_0000_4000_0000;
			cfg_q.rot2     <= 64'h0000_4000_0000_0000;
			cfg_q.trans_xy <= '0;
			cfg_q.trans_z  <= '0;
			cfg_q.focal    <= 64'h0100_0000_0100_0000;
			cfg_q.center   <= 64'h0080_0000_0080_0000;
			cfg_q.size     <= 32'h0100_0100;
		end else if (cfg_write) begin
			case (pczb_pkg::pczb_reg_t'(cfg_index))
				pczb_pkg::REG_ROT0:     cfg_q.rot0     <= cfg_data;
				pczb_pkg::REG_ROT1:     cfg_q.rot1     <= cfg_data;
				pczb_pkg::REG_ROT2:     cfg_q.rot2     <= cfg_data;
				pczb_pkg::REG_TRANS_XY: cfg_q.trans_xy <= cfg_data;
				pczb_pkg::REG_TRANS_Z:  cfg_q.trans_z  <= cfg_data[31:0];
				pczb_pkg::REG_FOCAL:    cfg_q.focal    <= cfg_data;
				pczb_pkg::REG_CENTER:   cfg_q.center   <= cfg_data;
				pczb_pkg::REG_SIZE:     cfg_q.size     <= cfg_data[31:0];
				default:                cfg_q          <= cfg_q;
			endcase
		end
	end

	// front: transform, divide, project, classify
	pczb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.hold          (clearing),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.z_coord       (z_coord),
		.pixel_address (pixel_address),
		.push          (push),
		.push_op       (push_op),
		.full          (full)
	);

	// queue lets the front run ahead of a stalled back
	pczb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	// back: depth store and result register
	pczb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.depth_value (depth_value),
		.pixel_empty (pixel_empty)
	);

endmodule

[sv/pczb_front.sv]
// front part: camera transform, projection and classification into store operations
module pczb_front #(
	parameter int MAX_WIDTH  = pczb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pczb_pkg::DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pczb_pkg::pczb_cfg_t       cfg,
	input  logic                      hold,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      kind,
	input  logic signed [31:0]        x_coord,
	input  logic signed [31:0]        y_coord,
	input  logic signed [31:0]        z_coord,
	input  logic [15:0]               pixel_address,
	output logic                      push,
	output pczb_pkg::pczb_op_t        push_op,
	input  logic                      full
);
	localparam int ACC_W = pczb_pkg::ACC_W;
	localparam int C_W   = pczb_pkg::C_W;
	localparam int DVD_W = pczb_pkg::DVD_W;
	localparam int U_W   = pczb_pkg::U_W;
	localparam int W_W   = $clog2(MAX_WIDTH + 1);
	localparam int H_W   = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_W = $clog2(DVD_W);

	typedef enum logic [3:0] {
		ST_IDLE, ST_XFORM, ST_ROUND, ST_DIV, ST_MULX, ST_MULY, ST_PROJ, ST_ADDR, ST_PUSH
	} state_t;

	state_t                   state_q;
	logic signed [31:0]       p_q [3];
	logic signed [ACC_W-1:0]  acc_q [3];
	logic signed [47:0]       prod_q;
	logic [1:0]               mrow_q, mcol_q, prow_q;
	logic                     pv_q;
	logic [3:0]               step_q;
	logic [C_W-1:0]           zc_q, rem_x_q, rem_y_q;
	logic [DVD_W-1:0]         quo_x_q, quo_y_q;
	logic                     neg_x_q, neg_y_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [47:0]              off_x_q, off_y_q;
	logic [W_W-1:0]           px_q;
	logic [H_W-1:0]           py_q;
	logic                     ok_q;
	pczb_pkg::pczb_op_t       op_q;

	logic [63:0]              rot_sel;
	logic signed [15:0]       r_sel;
	logic signed [31:0]       p_sel;
	logic signed [47:0]       prod_d;
	logic signed [ACC_W-1:0]  rnd [3];
	logic signed [C_W-1:0]    c [3];
	logic [C_W-1:0]           mag_x, mag_y;
	logic [C_W:0]             trial_x, trial_y;
	logic                     ge_x, ge_y;
	logic [31:0]              ratio_x, ratio_y, mul_a, mul_b;
	logic [63:0]              mul_p;
	logic [15:0]              w_reg, h_reg;
	logic [W_W-1:0]           weff;
	logic [H_W-1:0]           heff;
	logic signed [31:0]       cx, cy;
	logic signed [U_W-1:0]    u, v, u_r, v_r;
	logic                     u_ok, v_ok;
	logic [31:0]              addr_full;

	always_comb begin
		case (mrow_q)
			2'd0:    rot_sel = cfg.rot0;
			2'd1:    rot_sel = cfg.rot1;
			default: rot_sel = cfg.rot2;
		endcase
		case (mcol_q)
			2'd0:    begin r_sel = signed'(rot_sel[15:0]);  p_sel = p_q[0]; end
			2'd1:    begin r_sel = signed'(rot_sel[31:16]); p_sel = p_q[1]; end
			default: begin r_sel = signed'(rot_sel[47:32]); p_sel = p_q[2]; end
		endcase
		prod_d = r_sel * p_sel;
	end

	// round half up back to 16 fraction bits
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = acc_q[i] + ACC_W'(8192);
			c[i]   = C_W'(rnd[i] >>> 14);
		end
		mag_x = c[0][C_W-1] ? C_W'(-c[0]) : C_W'(c[0]);
		mag_y = c[1][C_W-1] ? C_W'(-c[1]) : C_W'(c[1]);
	end

	// one quotient bit per cycle for each axis
	assign trial_x = {rem_x_q, quo_x_q[DVD_W-1]};
	assign trial_y = {rem_y_q, quo_y_q[DVD_W-1]};
	assign ge_x    = trial_x >= {1'b0, zc_q};
	assign ge_y    = trial_y >= {1'b0, zc_q};

	assign ratio_x = (|quo_x_q[DVD_W-1:32]) ? 32'hFFFF_FFFF : quo_x_q[31:0];
	assign ratio_y = (|quo_y_q[DVD_W-1:32]) ? 32'hFFFF_FFFF : quo_y_q[31:0];
	assign mul_a   = (state_q == ST_MULX) ? cfg.focal[31:0] : cfg.focal[63:32];
	assign mul_b   = (state_q == ST_MULX) ? ratio_x : ratio_y;
	assign mul_p   = mul_a * mul_b;

	assign w_reg = cfg.size[15:0];
	assign h_reg = cfg.size[31:16];
	assign weff  = (w_reg > 16'(MAX_WIDTH))  ? W_W'(MAX_WIDTH)  : W_W'(w_reg);
	assign heff  = (h_reg > 16'(MAX_HEIGHT)) ? H_W'(MAX_HEIGHT) : H_W'(h_reg);
	assign cx    = signed'(cfg.center[31:0]);
	assign cy    = signed'(cfg.center[63:32]);

	always_comb begin
		u   = neg_x_q ? U_W'(cx) - signed'({2'b00, off_x_q}) : U_W'(cx) + signed'({2'b00, off_x_q});
		v   = neg_y_q ? U_W'(cy) - signed'({2'b00, off_y_q}) : U_W'(cy) + signed'({2'b00, off_y_q});
		u_r = (u + U_W'(32768)) >>> 16;
		v_r = (v + U_W'(32768)) >>> 16;
		// a coordinate below minus one half rounds to a negative pixel
		u_ok = (u > -U_W'(32768)) && ($unsigned(u_r) < U_W'(weff));
		v_ok = (v > -U_W'(32768)) && ($unsigned(v_r) < U_W'(heff));
	end

	assign addr_full = 32'(py_q) * 32'(weff) + 32'(px_q);

	assign in_stall = (state_q != ST_IDLE) || hold;
	assign push     = (state_q == ST_PUSH);
	assign push_op  = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pv_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !hold) begin
						if (kind) begin
							op_q    <= '{is_read: 1'b1, addr: pixel_address,
							             depth: pczb_pkg::DEPTH_EMPTY};
							state_q <= ST_PUSH;
						end else begin
							p_q[0]  <= x_coord;
							p_q[1]  <= y_coord;
							p_q[2]  <= z_coord;
							acc_q[0] <= ACC_W'(signed'(cfg.trans_xy[31:0])) <<< 14;
							acc_q[1] <= ACC_W'(signed'(cfg.trans_xy[63:32])) <<< 14;
							acc_q[2] <= ACC_W'(signed'(cfg.trans_z)) <<< 14;
							mrow_q  <= 2'd0;
							mcol_q  <= 2'd0;
							step_q  <= 4'd0;
							pv_q    <= 1'b0;
							state_q <= ST_XFORM;
						end
					end
				end
				ST_XFORM: begin
					prod_q <= prod_d;
					prow_q <= mrow_q;
					pv_q   <= (step_q < 4'd9);
					if (pv_q) acc_q[prow_q] <= acc_q[prow_q] + ACC_W'(prod_q);
					if (mcol_q == 2'd2) begin
						mcol_q <= 2'd0;
						mrow_q <= mrow_q + 2'd1;
					end else begin
						mcol_q <= mcol_q + 2'd1;
					end
					step_q <= step_q + 4'd1;
					if (step_q == 4'd9) state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					pv_q <= 1'b0;
					if (c[2][C_W-1] || c[2] == '0) begin
						state_q <= ST_IDLE;
					end else begin
						zc_q    <= C_W'(c[2]);
						neg_x_q <= c[0][C_W-1];
						neg_y_q <= c[1][C_W-1];
						quo_x_q <= {mag_x, 16'h0000};
						quo_y_q <= {mag_y, 16'h0000};
						rem_x_q <= '0;
						rem_y_q <= '0;
						cnt_q   <= CNT_W'(DVD_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_x_q <= ge_x ? C_W'(trial_x - {1'b0, zc_q}) : trial_x[C_W-1:0];
					rem_y_q <= ge_y ? C_W'(trial_y - {1'b0, zc_q}) : trial_y[C_W-1:0];
					quo_x_q <= {quo_x_q[DVD_W-2:0], ge_x};
					quo_y_q <= {quo_y_q[DVD_W-2:0], ge_y};
					cnt_q   <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) state_q <= ST_MULX;
				end
				ST_MULX: begin
					off_x_q <= mul_p[63:16];
					state_q <= ST_MULY;
				end
				ST_MULY: begin
					off_y_q <= mul_p[63:16];
					state_q <= ST_PROJ;
				end
				ST_PROJ: begin
					px_q    <= W_W'(u_r);
					py_q    <= H_W'(v_r);
					ok_q    <= u_ok && v_ok;
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					op_q.is_read <= 1'b0;
					op_q.addr    <= addr_full[pczb_pkg::ADDR_W-1:0];
					op_q.depth   <= (zc_q > C_W'(pczb_pkg::DEPTH_MAX_KEPT)) ?
					                pczb_pkg::DEPTH_MAX_KEPT : zc_q[31:0];
					state_q      <= ok_q ? ST_PUSH : ST_IDLE;
				end
				ST_PUSH: begin
					if (!full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/pczb_queue.sv]
// short operation queue between the front and the back
module pczb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pczb_pkg::pczb_op_t push_op,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output pczb_pkg::pczb_op_t head
);
	localparam int D   = pczb_pkg::QUEUE_DEPTH;
	localparam int P_W = $clog2(D);

	pczb_pkg::pczb_op_t mem_q [D];
	logic [P_W-1:0]     wr_q, rd_q;
	logic [P_W:0]       cnt_q;
	logic               do_push, do_pop;

	assign full    = (cnt_q == (P_W+1)'(D));
	assign empty   = (cnt_q == '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + P_W'(1);
			if (do_pop)  rd_q <= rd_q + P_W'(1);
			cnt_q <= cnt_q + (P_W+1)'(do_push) - (P_W+1)'(do_pop);
		end
	end

endmodule

[sv/pczb_back.sv]
// back part: depth store with clearing pass, depth test and read-and-clear
module pczb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  pczb_pkg::pczb_op_t head,
	output logic               pop,
	output logic               clearing,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        depth_value,
	output logic               pixel_empty
);
	localparam int A_W = pczb_pkg::ADDR_W;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RMW} state_t;

	state_t                 state_q;
	logic [31:0]            mem [1 << A_W];
	logic [31:0]            rdata_q;
	logic [A_W-1:0]         clr_q;
	pczb_pkg::pczb_op_t     cur_q;
	logic                   out_valid_q;
	logic [31:0]            data_q;
	logic                   empty_q;
	logic                   we;
	logic [A_W-1:0]         waddr;
	logic [31:0]            wdata;

	assign pop = (state_q == ST_IDLE) && !empty && (!head.is_read || !out_valid_q);

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = pczb_pkg::DEPTH_EMPTY;
		case (state_q)
			ST_CLEAR: we = 1'b1;
			ST_RMW: begin
				waddr = cur_q.addr;
				if (cur_q.is_read) begin
					we = 1'b1;
				end else begin
					we    = cur_q.depth < rdata_q;
					wdata = cur_q.depth;
				end
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[head.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + A_W'(1);
					if (&clr_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop) begin
						cur_q   <= head;
						state_q <= ST_RMW;
					end
				end
				ST_RMW: begin
					if (cur_q.is_read) begin
						data_q      <= rdata_q;
						empty_q     <= (rdata_q == pczb_pkg::DEPTH_EMPTY);
						out_valid_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign clearing    = (state_q == ST_CLEAR);
	assign out_valid   = out_valid_q;
	assign depth_value = data_q;
	assign pixel_empty = empty_q;

endmodule
